### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; all sample on clk, disabled under rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sqid_pkg.sv
// ---------------------------------------------------------------------------
// sqid_pkg
// Shared types and fixed constants of the sliding quantile interval detector.
// ---------------------------------------------------------------------------
package sqid_pkg;

  localparam int TAG_BITS    = 21;
  localparam int THR_BITS    = 11;
  localparam int RANK_BITS   = 5;
  localparam int SCORE_BITS  = 11;
  localparam int DIV_W       = 32;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [DIV_W-1:0]    SCORE_SCALE   = 32'd2000;
  localparam logic [THR_BITS-1:0] RST_THRESHOLD = 11'd10;
  localparam logic                RST_ENABLE    = 1'b1;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_DETECT_ENABLE   = 2'd0;
  localparam logic [1:0] REG_ALERT_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_QUANTILE_RANK   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PREP,
    ST_MERGE,
    ST_MOD_GO,
    ST_MOD,
    ST_DIV_GO,
    ST_DIV,
    ST_DONE
  } sqid_state_t;

endpackage

### src/sqid_in_if.sv
// ---------------------------------------------------------------------------
// sqid_in_if
// Sample channel: valid/ready handshake carrying one interval sample beat.
// ---------------------------------------------------------------------------
interface sqid_in_if #(
  parameter int SAMPLE_BITS = 21
);
  logic                          valid;
  logic                          ready;
  logic [SAMPLE_BITS-1:0]        interval_sample;
  logic                          packet_valid;
  logic [sqid_pkg::TAG_BITS-1:0] setting_tag;

  modport source (output valid, interval_sample, packet_valid, setting_tag, input ready);
  modport sink   (input valid, interval_sample, packet_valid, setting_tag, output ready);
endinterface

### src/sqid_out_if.sv
// ---------------------------------------------------------------------------
// sqid_out_if
// Result channel: valid/ready handshake carrying one detection result beat.
// ---------------------------------------------------------------------------
interface sqid_out_if #(
  parameter int SAMPLE_BITS = 21
);
  logic                            valid;
  logic                            ready;
  logic                            alert;
  logic [sqid_pkg::SCORE_BITS-1:0] deviation_score;
  logic                            window_ready;
  logic [SAMPLE_BITS-1:0]          reference_value;

  modport source (output valid, alert, deviation_score, window_ready, reference_value,
                  input ready);
  modport sink   (input valid, alert, deviation_score, window_ready, reference_value,
                  output ready);
endinterface

### src/sliding_quantile_interval_detector.sv
// ---------------------------------------------------------------------------
// sliding_quantile_interval_detector
// Sorted sliding window of interval samples with order-statistic deviation.
// ---------------------------------------------------------------------------
//
//  Channel | Dir | Handshake               | Beat contents
//  --------+-----+-------------------------+------------------------------------
//  in_ch   | in  | valid/ready             | interval_sample, packet_valid, tag
//  out_ch  | out | valid/ready             | alert, score, window_ready, ref
//  cfg     | in  | APB psel/penable/pready | detect_enable, threshold, rank
//
//  Sequencing: an ignored sample goes from idle straight to done; a kept
//  sample is fetched, prepared and merged. The merge pass walks the sorted
//  memory one entry a cycle. Once the window is full and the reference is
//  nonzero, the shared divider runs twice at one quotient bit a cycle
//  (modulo, then scaling).
//  Reset: control state and the window bookkeeping clear synchronously; the
//  window memories need no clearing pass.
//  Stalls: in_ch.ready is high only in idle; a result held by out_ch stalls
//  the next result's hand-off but not the next sample's acceptance.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_quantile_interval_detector #(
  parameter int WINDOW_DEPTH = 24,
  parameter int SAMPLE_BITS  = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sqid_in_if.sink                       in_ch,
  sqid_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sqid_pkg::PADDR_W-1:0]  paddr,
  input  logic [sqid_pkg::PDATA_W-1:0]  pwdata,
  output logic [sqid_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SB     = SAMPLE_BITS;
  localparam int DW     = sqid_pkg::DIV_W;
  localparam int TB     = sqid_pkg::TAG_BITS;
  localparam int SCB    = sqid_pkg::SCORE_BITS;
  localparam int MEM_D  = 2 ** (IDX_W + 1);
  localparam logic [sqid_pkg::RANK_BITS-1:0] RST_RANK =
    sqid_pkg::RANK_BITS'(WINDOW_DEPTH / 6);

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic                              en_r;
  logic [sqid_pkg::THR_BITS-1:0]     thr_r;
  logic [sqid_pkg::RANK_BITS-1:0]    rank_r;
  logic                              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= sqid_pkg::RST_ENABLE;
      thr_r  <= sqid_pkg::RST_THRESHOLD;
      rank_r <= RST_RANK;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sqid_pkg::REG_DETECT_ENABLE:   en_r   <= pwdata[0];
        sqid_pkg::REG_ALERT_THRESHOLD: thr_r  <= pwdata[sqid_pkg::THR_BITS-1:0];
        sqid_pkg::REG_QUANTILE_RANK:   rank_r <= pwdata[sqid_pkg::RANK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sqid_pkg::REG_DETECT_ENABLE:   prdata = sqid_pkg::PDATA_W'(en_r);
      sqid_pkg::REG_ALERT_THRESHOLD: prdata = sqid_pkg::PDATA_W'(thr_r);
      sqid_pkg::REG_QUANTILE_RANK:   prdata = sqid_pkg::PDATA_W'(rank_r);
      default:                       prdata = '0;
    endcase
  end

  // Saturate the rank into the window
  logic [IDX_W-1:0] rank_eff;
  always_comb begin
    if (32'(rank_r) >= 32'(WINDOW_DEPTH)) rank_eff = IDX_W'(WINDOW_DEPTH - 1);
    else                                  rank_eff = IDX_W'(rank_r);
  end

  // -------------------------------------------------------------------------
  // State and working registers
  // -------------------------------------------------------------------------
  sqid_pkg::sqid_state_t state_r, state_nxt;

  logic [IDX_W-1:0] w_r;        // ring write slot
  logic             filled_r;   // window holds WINDOW_DEPTH samples
  logic [TB-1:0]    last_tag_r;
  logic             bank_r;     // sorted bank currently valid

  logic [SB-1:0]    sample_r;
  logic [SB-1:0]    q_r;
  logic [SB-1:0]    old_r;      // sample leaving the window
  logic             ready_r;
  logic [SCB-1:0]   score_r;
  logic [DW-1:0]    num_r;

  logic [CNT_W-1:0] k_r, k_nxt; // source index of merge pass
  logic [CNT_W-1:0] j_r, j_nxt; // destination index of merge pass
  logic [CNT_W-1:0] n_r;        // source length
  logic             rem_pend_r; // oldest sample still to drop
  logic             ins_pend_r; // new sample still to place

  logic             out_valid_r;
  logic             out_alert_r;
  logic [SCB-1:0]   out_score_r;
  logic             out_wready_r;
  logic [SB-1:0]    out_ref_r;

  // -------------------------------------------------------------------------
  // Window memories: sorted values in two banks, samples in arrival order
  // -------------------------------------------------------------------------
  logic [SB-1:0]    sort_mem [MEM_D];
  logic [SB-1:0]    ring_mem [WINDOW_DEPTH];
  logic [SB-1:0]    rd_q;
  logic [SB-1:0]    ring_q;
  logic [IDX_W-1:0] rd_idx;
  logic             wr_en;
  logic [SB-1:0]    wr_data;
  logic             ring_wr;

  always_ff @(posedge clk) begin
    rd_q <= sort_mem[{bank_r, rd_idx}];
    if (wr_en) sort_mem[{~bank_r, j_r[IDX_W-1:0]}] <= wr_data;
  end

  always_ff @(posedge clk) begin
    ring_q <= ring_mem[w_r];
    if (ring_wr) ring_mem[w_r] <= sample_r;
  end

  // -------------------------------------------------------------------------
  // Merge step: drop the oldest sample, place the new one, copy the rest
  // -------------------------------------------------------------------------
  logic src_ok, m_skip, m_ins, m_cpy, m_fin;

  always_comb begin
    src_ok = k_r < n_r;
    m_skip = rem_pend_r && src_ok && (rd_q == old_r);
    // ties: the new sample goes after equal values already present
    m_ins  = !m_skip && ins_pend_r && (!src_ok || (rd_q > sample_r));
    m_cpy  = !m_skip && !m_ins && src_ok;
    m_fin  = !m_skip && !m_ins && !src_ok;
  end

  // -------------------------------------------------------------------------
  // Shared divider
  // -------------------------------------------------------------------------
  logic           div_start;
  logic [DW-1:0]  div_dividend;
  logic           div_done;
  logic [DW-1:0]  div_quo;
  logic [SB-1:0]  div_rem;
  logic [SB-1:0]  half;
  logic [SB-1:0]  dev;
  logic           div_wait;

  assign half     = q_r >> 1;
  assign dev      = (div_rem >= half) ? (div_rem - half) : (half - div_rem);
  assign div_wait = (state_r == sqid_pkg::ST_MOD) || (state_r == sqid_pkg::ST_DIV);

  sqid_div #(
    .SAMPLE_BITS(SB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (q_r),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  logic in_ready;
  logic in_acc;
  logic in_skip;
  logic out_load;

  assign in_acc  = in_ch.valid && in_ready;
  assign in_skip = !en_r || !in_ch.packet_valid || (in_ch.interval_sample == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sqid_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = in_skip ? sqid_pkg::ST_DONE : sqid_pkg::ST_FETCH;
      end
      sqid_pkg::ST_FETCH:  state_nxt = sqid_pkg::ST_PREP;
      sqid_pkg::ST_PREP:   state_nxt = sqid_pkg::ST_MERGE;
      sqid_pkg::ST_MERGE: begin
        if (m_fin) begin
          state_nxt = (ready_r && (q_r != '0)) ? sqid_pkg::ST_MOD_GO : sqid_pkg::ST_DONE;
        end
      end
      sqid_pkg::ST_MOD_GO: state_nxt = sqid_pkg::ST_MOD;
      sqid_pkg::ST_MOD: begin
        if (div_done) state_nxt = sqid_pkg::ST_DIV_GO;
      end
      sqid_pkg::ST_DIV_GO: state_nxt = sqid_pkg::ST_DIV;
      sqid_pkg::ST_DIV: begin
        if (div_done) state_nxt = sqid_pkg::ST_DONE;
      end
      sqid_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = sqid_pkg::ST_IDLE;
      end
      default: state_nxt = sqid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = num_r;
    wr_en        = 1'b0;
    wr_data      = m_ins ? sample_r : rd_q;
    ring_wr      = 1'b0;
    rd_idx       = k_nxt[IDX_W-1:0];
    out_load     = 1'b0;
    unique case (state_r)
      sqid_pkg::ST_IDLE:   in_ready = 1'b1;
      sqid_pkg::ST_FETCH:  rd_idx   = rank_eff;
      sqid_pkg::ST_PREP: begin
        rd_idx  = '0;
        ring_wr = 1'b1;
      end
      sqid_pkg::ST_MERGE:  wr_en = m_ins || m_cpy;
      sqid_pkg::ST_MOD_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(sample_r) - DW'(half);
      end
      sqid_pkg::ST_DIV_GO: div_start = 1'b1;
      sqid_pkg::ST_DONE:   out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_comb begin
    k_nxt = k_r;
    j_nxt = j_r;
    if (state_r == sqid_pkg::ST_MERGE) begin
      if (m_skip || m_cpy) k_nxt = k_r + 1'b1;
      if (m_ins || m_cpy)  j_nxt = j_r + 1'b1;
    end else if (state_r == sqid_pkg::ST_PREP) begin
      k_nxt = '0;
      j_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqid_pkg::ST_IDLE;
      w_r         <= '0;
      filled_r    <= 1'b0;
      last_tag_r  <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      rem_pend_r  <= 1'b0;
      ins_pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      // restart the window on a new setting tag
      if (in_acc && !in_skip) begin
        last_tag_r <= in_ch.setting_tag;
        if (in_ch.setting_tag != last_tag_r) begin
          w_r      <= '0;
          filled_r <= 1'b0;
        end
      end
      if (state_r == sqid_pkg::ST_PREP) begin
        rem_pend_r <= filled_r;
        ins_pend_r <= 1'b1;
      end else if (state_r == sqid_pkg::ST_MERGE) begin
        if (m_skip) rem_pend_r <= 1'b0;
        if (m_ins)  ins_pend_r <= 1'b0;
        // commit: flip banks, advance the ring slot
        if (m_fin) begin
          bank_r <= ~bank_r;
          if (w_r == IDX_W'(WINDOW_DEPTH - 1)) begin
            w_r      <= '0;
            filled_r <= 1'b1;
          end else begin
            w_r <= w_r + 1'b1;
          end
        end
      end
      if (out_load)                        out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_ch.interval_sample;
      ready_r  <= 1'b0;
      q_r      <= '0;
      score_r  <= '0;
    end
    if (state_r == sqid_pkg::ST_PREP) begin
      ready_r <= filled_r;
      q_r     <= filled_r ? rd_q : '0;
      old_r   <= ring_q;
      n_r     <= filled_r ? CNT_W'(WINDOW_DEPTH) : CNT_W'(w_r);
    end
    // scale the folded deviation, then divide by q
    if (state_r == sqid_pkg::ST_MOD && div_done) begin
      num_r <= DW'(dev) * sqid_pkg::SCORE_SCALE;
    end
    if (state_r == sqid_pkg::ST_DIV && div_done) begin
      score_r <= div_quo[SCB-1:0];
    end
    if (out_load) begin
      out_alert_r  <= (score_r != '0) && (score_r <= thr_r);
      out_score_r  <= score_r;
      out_wready_r <= ready_r;
      out_ref_r    <= q_r;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.alert           = out_alert_r;
  assign out_ch.deviation_score = out_score_r;
  assign out_ch.window_ready    = out_wready_r;
  assign out_ch.reference_value = out_ref_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ch.ready, "ready high right after accept")
  `ASSERT_IMPLIES(a_merge_in_range, wr_en, j_r < CNT_W'(WINDOW_DEPTH), "merge write overflow")
  `ASSERT_ALWAYS(a_slot_in_range, w_r <= IDX_W'(WINDOW_DEPTH - 1), "write slot out of window")
  `ASSERT_IMPLIES(a_div_done_waited, div_done, div_wait, "divider done while not waiting")

endmodule

### src/sqid_div.sv
// ---------------------------------------------------------------------------
// sqid_div
// Restoring divider, one quotient bit per cycle; quotient and remainder.
// ---------------------------------------------------------------------------
module sqid_div #(
  parameter int SAMPLE_BITS = 21
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sqid_pkg::DIV_W-1:0]   dividend,
  input  logic [SAMPLE_BITS-1:0]       divisor,
  output logic                         done,
  output logic [sqid_pkg::DIV_W-1:0]   quotient,
  output logic [SAMPLE_BITS-1:0]       remainder
);

  localparam int DW    = sqid_pkg::DIV_W;
  localparam int CNT_W = $clog2(DW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [SAMPLE_BITS-1:0] rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] dvs_r, dvs_nxt;

  logic [SAMPLE_BITS:0] rem_sh;
  logic [SAMPLE_BITS:0] diff;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DW-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DW - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // subtract when no borrow, else keep the shifted remainder
      if (!diff[SAMPLE_BITS]) begin
        rem_nxt = diff[SAMPLE_BITS-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[SAMPLE_BITS-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
